### design/tt_pkg.sv
// touch tap tracker package: table size, field widths, event kinds, status codes
// and configuration register indexes
// used by touch_tap_tracker_unit
package tt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int POS_W = 13;
    localparam int VIEW_W = 14;
    localparam int ID_W = 8;

    typedef logic [1:0] kind_t;
    typedef logic [1:0] status_t;
    typedef logic [1:0] cfg_index_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic signed [VIEW_W-1:0] view_t;
    typedef logic [ID_W-1:0] id_t;

    localparam kind_t KIND_PRESS = 2'd0;
    localparam kind_t KIND_RELEASE = 2'd1;
    localparam kind_t KIND_CANCEL = 2'd2;

    localparam status_t ST_OK = 2'd0;
    localparam status_t ST_FULL = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;

    localparam cfg_index_t REG_WIDTH = 2'd0;
    localparam cfg_index_t REG_HEIGHT = 2'd1;
    localparam cfg_index_t REG_ORIENT = 2'd2;

    localparam logic [1:0] ORIENT_PORTRAIT = 2'd0;
    localparam logic [1:0] ORIENT_PORTRAIT_FLIP = 2'd1;
    localparam logic [1:0] ORIENT_LAND_RIGHT = 2'd2;

    localparam pos_t WIDTH_RESET = 13'd1080;
    localparam pos_t HEIGHT_RESET = 13'd1920;

    typedef struct packed {
        id_t   id;
        view_t x;
        view_t y;
    } entry_t;

endpackage

### design/touch_tap_tracker_unit.sv
// touch tap tracker top level: orientation remap, pointer table memory, tap test
// depends on tt_pkg

// One touch event is taken at a time. It is remapped for the configured
// orientation when accepted, then the pointer table memory is read one entry per
// cycle to find the pointer and the lowest free entry, and the table is updated
// and the result word loaded into the output register. The scan reads every
// entry in turn through the single read port of the table memory; the next
// event is accepted in the cycle after the result is loaded, even while that
// result still waits on out_stall. Entry valid bits are flip-flops cleared by
// reset, so no clearing pass is needed. Configuration may be written only while
// no event is in flight.
module touch_tap_tracker_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  tt_pkg::cfg_index_t   cfg_index,
    input  tt_pkg::pos_t         cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tt_pkg::kind_t        kind,
    input  tt_pkg::id_t          touch_id,
    input  tt_pkg::pos_t         raw_x,
    input  tt_pkg::pos_t         raw_y,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tt_pkg::view_t        view_x,
    output tt_pkg::view_t        view_y,
    output logic                 tap,
    output tt_pkg::status_t      status
);

    import tt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_SCAN    = 3'b010,
        S_RESOLVE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    pos_t width_reg, height_reg;
    logic [1:0] orient_reg;

    entry_t mem [TABLE_ENTRIES];
    entry_t mem_q;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    kind_t kind_reg;
    id_t id_reg;
    view_t vx_reg, vy_reg;
    view_t vx_c, vy_c;

    logic [CNT_W-1:0] cnt_reg;
    logic rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic hit_reg, free_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg;
    view_t hit_x_reg, hit_y_reg;

    logic out_valid_reg, tap_reg;
    view_t out_x_reg, out_y_reg;
    status_t status_reg;

    logic accept, commit, scan_issue, match;
    logic mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t mem_wdata;
    logic tap_c;
    status_t status_c;
    logic signed [VIEW_W:0] dx, dy;
    logic [VIEW_W-1:0] adx, ady;
    logic [VIEW_W+4:0] dx20, dy20;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign commit = (state_reg == S_RESOLVE) && (!out_valid_reg || !out_stall);
    assign scan_issue = (state_reg == S_SCAN) && (cnt_reg < CNT_W'(TABLE_ENTRIES));
    assign match = rd_pend_reg && valid_reg[rd_idx_reg] && (mem_q.id == id_reg);

    always_comb
    begin
        case (orient_reg)
            ORIENT_PORTRAIT:
            begin
                vx_c = $signed({1'b0, raw_x});
                vy_c = $signed({1'b0, height_reg}) - $signed({1'b0, raw_y});
            end
            ORIENT_PORTRAIT_FLIP:
            begin
                vx_c = $signed({1'b0, width_reg}) - $signed({1'b0, raw_x});
                vy_c = $signed({1'b0, raw_y});
            end
            ORIENT_LAND_RIGHT:
            begin
                vx_c = $signed({1'b0, raw_y});
                vy_c = $signed({1'b0, raw_x});
            end
            default:
            begin
                vx_c = $signed({1'b0, height_reg}) - $signed({1'b0, raw_y});
                vy_c = $signed({1'b0, width_reg}) - $signed({1'b0, raw_x});
            end
        endcase
    end

    // tap tolerance: 20 * |d| <= size
    always_comb
    begin
        dx = {vx_reg[VIEW_W-1], vx_reg} - {hit_x_reg[VIEW_W-1], hit_x_reg};
        dy = {vy_reg[VIEW_W-1], vy_reg} - {hit_y_reg[VIEW_W-1], hit_y_reg};
        adx = dx[VIEW_W] ? VIEW_W'(-dx) : VIEW_W'(dx);
        ady = dy[VIEW_W] ? VIEW_W'(-dy) : VIEW_W'(dy);
        dx20 = ({5'b0, adx} << 4) + ({5'b0, adx} << 2);
        dy20 = ({5'b0, ady} << 4) + ({5'b0, ady} << 2);
        tap_c = (dx20 <= {6'b0, width_reg}) && (dy20 <= {6'b0, height_reg});
    end

    always_comb
    begin
        status_c = ST_OK;
        mem_we = 1'b0;
        mem_waddr = hit_idx_reg;
        mem_wdata = '{id: id_reg, x: vx_reg, y: vy_reg};
        case (kind_reg)
            KIND_PRESS:
            begin
                if (hit_reg)
                begin
                    mem_we = commit;
                end
                else if (free_reg)
                begin
                    mem_we = commit;
                    mem_waddr = free_idx_reg;
                end
                else
                begin
                    status_c = ST_FULL;
                end
            end
            KIND_RELEASE, KIND_CANCEL:
            begin
                if (!hit_reg)
                begin
                    status_c = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!scan_issue && !rd_pend_reg)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            orient_reg <= ORIENT_PORTRAIT;
            valid_reg <= '0;
            cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WIDTH:  width_reg <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_ORIENT: orient_reg <= cfg_data[1:0];
                    default:    orient_reg <= orient_reg;
                endcase
            end
            if (accept)
            begin
                cnt_reg <= '0;
                hit_reg <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (scan_issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            rd_pend_reg <= scan_issue;
            if (match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (rd_pend_reg && !valid_reg[rd_idx_reg] && !free_reg)
            begin
                free_reg <= 1'b1;
            end
            if (commit)
            begin
                if (kind_reg == KIND_PRESS && !hit_reg && free_reg)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                if ((kind_reg == KIND_RELEASE || kind_reg == KIND_CANCEL) && hit_reg)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            id_reg <= touch_id;
            vx_reg <= vx_c;
            vy_reg <= vy_c;
        end
        rd_idx_reg <= cnt_reg[IDX_W-1:0];
        if (match && !hit_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_x_reg <= mem_q.x;
            hit_y_reg <= mem_q.y;
        end
        if (rd_pend_reg && !valid_reg[rd_idx_reg] && !free_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (commit)
        begin
            out_x_reg <= vx_reg;
            out_y_reg <= vy_reg;
            status_reg <= status_c;
            tap_reg <= (kind_reg == KIND_RELEASE) && hit_reg && tap_c;
        end
    end

    // pointer table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_issue)
        begin
            mem_q <= mem[cnt_reg[IDX_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign view_x = out_x_reg;
    assign view_y = out_y_reg;
    assign tap = tap_reg;
    assign status = status_reg;

    a_tap_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tap |-> status == ST_OK)
        else $error("tap reported with non-ok status");

    a_full_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit && status_c == ST_FULL |-> &valid_reg)
        else $error("press dropped while a free entry exists");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("scan counter past table end");

    a_commit_frees_stage: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not loaded after commit");

endmodule

### test/touch_tap_tracker_unit_tb.sv
`timescale 1ns / 100ps
// testbench for touch_tap_tracker_unit: drives touch events and register writes,
// predicts remapped coordinates, tap flags and status, and checks every result word
// depends on tt_pkg and the touch_tap_tracker_unit rtl
module touch_tap_tracker_unit_tb;

    import tt_pkg::*;

    localparam kind_t KIND_UNUSED = 2'd3;
    localparam logic [1:0] ORIENT_LAND_LEFT = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_POS = 8191;

    typedef struct {
        view_t   vx;
        view_t   vy;
        logic    tap;
        status_t status;
    } touch_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    cfg_index_t cfg_index = REG_WIDTH;
    pos_t       cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    kind_t      kind = KIND_PRESS;
    id_t        touch_id = '0;
    pos_t       raw_x = '0;
    pos_t       raw_y = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    view_t      view_x;
    view_t      view_y;
    logic       tap;
    status_t    status;

    touch_tap_tracker_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .touch_id   (touch_id),
        .raw_x      (raw_x),
        .raw_y      (raw_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .view_x     (view_x),
        .view_y     (view_y),
        .tap        (tap),
        .status     (status)
    );

    always #5 clk = ~clk;

    // tracker copy: pointer table and registers
    bit         slot_used [TABLE_ENTRIES];
    id_t        slot_id [TABLE_ENTRIES];
    int         slot_x [TABLE_ENTRIES];
    int         slot_y [TABLE_ENTRIES];
    int         cur_width = WIDTH_RESET;
    int         cur_height = HEIGHT_RESET;
    logic [1:0] cur_orient = ORIENT_PORTRAIT;

    // raw press position per pointer, used to aim releases near their press
    bit         pressed_raw [256];
    pos_t       press_raw_x [256];
    pos_t       press_raw_y [256];

    touch_result_t awaited_results [$];

    int  error_count = 0;
    int  sent_count = 0;
    int  checked_count = 0;
    int  tap_count = 0;
    int  full_count = 0;
    int  missing_count = 0;
    int  reg_writes = 0;
    bit  idle_en = 1'b1;
    int  hold_len = 0;
    bit  hold_go = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    function automatic touch_result_t track_touch(kind_t k, id_t id, pos_t rx, pos_t ry);
        touch_result_t r;
        int vx;
        int vy;
        int hit;
        int free_slot;
        int dx;
        int dy;
        case (cur_orient)
            ORIENT_PORTRAIT:
            begin
                vx = int'(rx);
                vy = cur_height - int'(ry);
            end
            ORIENT_PORTRAIT_FLIP:
            begin
                vx = cur_width - int'(rx);
                vy = int'(ry);
            end
            ORIENT_LAND_RIGHT:
            begin
                vx = int'(ry);
                vy = int'(rx);
            end
            default:
            begin
                vx = cur_height - int'(ry);
                vy = cur_width - int'(rx);
            end
        endcase
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (hit < 0 && slot_used[i] && slot_id[i] == id)
                hit = i;
            if (free_slot < 0 && !slot_used[i])
                free_slot = i;
        end
        r.vx = view_t'(vx);
        r.vy = view_t'(vy);
        r.tap = 1'b0;
        r.status = ST_OK;
        if (k == KIND_PRESS)
        begin
            if (hit < 0 && free_slot >= 0)
            begin
                hit = free_slot;
                slot_used[hit] = 1'b1;
                slot_id[hit] = id;
            end
            if (hit >= 0)
            begin
                slot_x[hit] = vx;
                slot_y[hit] = vy;
            end
            else
                r.status = ST_FULL;
        end
        else if (k == KIND_RELEASE || k == KIND_CANCEL)
        begin
            if (hit < 0)
                r.status = ST_NOT_FOUND;
            else
            begin
                slot_used[hit] = 1'b0;
                dx = vx - slot_x[hit];
                dy = vy - slot_y[hit];
                if (dx < 0)
                    dx = -dx;
                if (dy < 0)
                    dy = -dy;
                if (k == KIND_RELEASE && 20 * dx <= cur_width && 20 * dy <= cur_height)
                    r.tap = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("tb: mismatch on %s after %0d results: got %0d, expected %0d",
                 what, checked_count, got, want);
        error_count++;
    endtask

    // result checker and receiver stall driver
    always @(posedge clk)
    begin
        touch_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("word with nothing expected", 0, 0);
            else
            begin
                want = awaited_results.pop_front();
                if (view_x !== want.vx)
                    report_mismatch("view_x", int'(view_x), int'(want.vx));
                if (view_y !== want.vy)
                    report_mismatch("view_y", int'(view_y), int'(want.vy));
                if (tap !== want.tap)
                    report_mismatch("tap", int'(tap), int'(want.tap));
                if (status !== want.status)
                    report_mismatch("status", int'(status), int'(want.status));
                if (want.tap)
                    tap_count++;
                if (want.status == ST_FULL)
                    full_count++;
                if (want.status == ST_NOT_FOUND)
                    missing_count++;
            end
            checked_count++;
        end
        if (hold_seen != hold_go)
        begin
            hold_seen <= hold_go;
            hold_left <= hold_len;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_en && ($urandom_range(99) < 29);
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_touch(kind_t k, id_t id, pos_t rx, pos_t ry);
        if (idle_en && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        touch_id <= id;
        raw_x <= rx;
        raw_y <= ry;
        do
            @(posedge clk);
        while (in_stall);
        awaited_results.push_back(track_touch(k, id, rx, ry));
        sent_count++;
    endtask

    // stop sending and wait until every expected word has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, pos_t value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_WIDTH: cur_width = int'(value);
            REG_HEIGHT: cur_height = int'(value);
            REG_ORIENT: cur_orient = value[1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_screen(int w, int h, logic [1:0] o);
        write_reg(REG_WIDTH, pos_t'(w));
        write_reg(REG_HEIGHT, pos_t'(h));
        write_reg(REG_ORIENT, pos_t'(o));
    endtask

    function automatic pos_t clamp_pos(int v);
        if (v < 0)
            return '0;
        if (v > MAX_POS)
            return pos_t'(MAX_POS);
        return pos_t'(v);
    endfunction

    task automatic random_touch(int id_span, int press_pct);
        int pick;
        int tol;
        id_t id;
        kind_t k;
        pos_t rx;
        pos_t ry;
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0)
            id = id_t'($urandom);
        else
            id = id_t'($urandom_range(id_span - 1));
        if (pick < press_pct)
            k = KIND_PRESS;
        else if (pick < press_pct + (100 - press_pct) * 7 / 10)
            k = KIND_RELEASE;
        else if (pick < 96)
            k = KIND_CANCEL;
        else
            k = KIND_UNUSED;
        rx = pos_t'($urandom);
        ry = pos_t'($urandom);
        if (k == KIND_RELEASE && pressed_raw[id] && $urandom_range(9) < 8)
        begin
            tol = (cur_width > cur_height ? cur_width : cur_height) / 20 + 2;
            rx = clamp_pos(int'(press_raw_x[id]) + $urandom_range(2 * tol) - tol);
            ry = clamp_pos(int'(press_raw_y[id]) + $urandom_range(2 * tol) - tol);
        end
        if (k == KIND_PRESS)
        begin
            pressed_raw[id] = 1'b1;
            press_raw_x[id] = rx;
            press_raw_y[id] = ry;
        end
        send_touch(k, id, rx, ry);
    endtask

    task automatic test_directed();
        send_touch(KIND_PRESS, 8'd0, 13'd0, 13'd0);
        send_touch(KIND_RELEASE, 8'd0, 13'd0, 13'd0);
        // horizontal tolerance just inside and just outside
        send_touch(KIND_PRESS, 8'd255, 13'd8191, 13'd8191);
        send_touch(KIND_RELEASE, 8'd255, 13'd8137, 13'd8191);
        send_touch(KIND_PRESS, 8'd255, 13'd8191, 13'd8191);
        send_touch(KIND_RELEASE, 8'd255, 13'd8136, 13'd8191);
        send_touch(KIND_RELEASE, 8'd7, 13'd100, 13'd200);
        send_touch(KIND_CANCEL, 8'd9, 13'd4095, 13'd4096);
        // press update, cancel, then release of a freed pointer
        send_touch(KIND_PRESS, 8'd5, 13'd10, 13'd20);
        send_touch(KIND_PRESS, 8'd5, 13'd5000, 13'd6000);
        send_touch(KIND_CANCEL, 8'd5, 13'd5000, 13'd6000);
        send_touch(KIND_RELEASE, 8'd5, 13'd5000, 13'd6000);
        send_touch(KIND_UNUSED, 8'd170, 13'd5461, 13'd2730);
        // vertical tolerance just inside and just outside
        send_touch(KIND_PRESS, 8'd1, 13'd100, 13'd500);
        send_touch(KIND_RELEASE, 8'd1, 13'd100, 13'd596);
        send_touch(KIND_PRESS, 8'd2, 13'd100, 13'd500);
        send_touch(KIND_RELEASE, 8'd2, 13'd100, 13'd403);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < TABLE_ENTRIES; i++)
            send_touch(KIND_PRESS, id_t'(100 + i), pos_t'($urandom), pos_t'($urandom));
        send_touch(KIND_PRESS, 8'd200, 13'd1, 13'd1);
        send_touch(KIND_PRESS, 8'd100, 13'd300, 13'd300);
        send_touch(KIND_RELEASE, 8'd120, 13'd300, 13'd300);
        send_touch(KIND_PRESS, 8'd201, 13'd50, 13'd60);
        send_touch(KIND_PRESS, 8'd202, 13'd50, 13'd60);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (i != 20)
                send_touch(KIND_CANCEL, id_t'(100 + i), pos_t'($urandom), pos_t'($urandom));
        send_touch(KIND_RELEASE, 8'd201, 13'd51, 13'd61);
    endtask

    task automatic test_zero_size();
        settle();
        set_screen(0, 0, ORIENT_LAND_LEFT);
        send_touch(KIND_PRESS, 8'd3, 13'd8191, 13'd0);
        send_touch(KIND_RELEASE, 8'd3, 13'd8191, 13'd0);
        send_touch(KIND_PRESS, 8'd4, 13'd8191, 13'd8191);
        send_touch(KIND_RELEASE, 8'd4, 13'd8190, 13'd8191);
    endtask

    task automatic test_orientations();
        logic [1:0] o;
        for (int n = 0; n < 4; n++)
        begin
            o = 2'(n);
            settle();
            set_screen($urandom_range(200, 4000), $urandom_range(200, 4000), o);
            repeat (20)
                random_touch(6, 50);
        end
    endtask

    task automatic test_backpressure();
        settle();
        idle_en = 1'b0;
        hold_len = 300;
        hold_go = !hold_go;
        repeat (30)
            random_touch(10, 50);
        settle();
        idle_en = 1'b1;
    endtask

    task automatic test_random_sessions();
        int w;
        int h;
        logic [1:0] o;
        for (int p = 0; p < 8; p++)
        begin
            settle();
            w = (p == 1) ? 1 : (p == 2) ? MAX_POS : (p == 5) ? 0 : $urandom_range(1, MAX_POS);
            h = (p == 1) ? MAX_POS : (p == 2) ? 1 : (p == 6) ? 0 : $urandom_range(1, MAX_POS);
            o = 2'(p % 4);
            set_screen(w, h, o);
            idle_en = (p != 3);
            for (int i = 0; i < 180; i++)
            begin
                if (i == 90)
                    settle();
                // some phases lean on presses so the table fills up
                if (p % 3 == 2)
                    random_touch(48, 75);
                else
                    random_touch(40, 50);
            end
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_zero_size();
        test_orientations();
        test_backpressure();
        test_random_sessions();
        settle();
        repeat (50) @(posedge clk);
        $display("tb: %0d events checked over %0d register writes in all four orientations",
                 checked_count, reg_writes);
        $display("tb: %0d taps, %0d presses dropped on a full table, %0d unknown pointers",
                 tap_count, full_count, missing_count);
        if (error_count == 0 && checked_count == sent_count)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
